FILE: design/edf_pkg.sv
// Shared constants and types for the EDF tick scheduler.
`timescale 1ns / 1ps
package edf_pkg;

  localparam int unsigned CFG_DATA_BITS = 64;
  localparam int unsigned FIELD_BITS    = 16;

  // task word layout
  localparam int unsigned PHASE_LSB  = 48;
  localparam int unsigned PERIOD_LSB = 32;
  localparam int unsigned WCET_LSB   = 16;
  localparam int unsigned DLINE_LSB  = 0;

  // config register indexes; task i word sits at CFG_TASK_BASE + i
  localparam int unsigned CFG_ENABLE    = 0;
  localparam int unsigned CFG_TASK_BASE = 1;

  typedef struct packed {
    logic clear;  // free every slot
    logic run;    // charge one tick to the selected slot
  } cell_cmd_t;

endpackage

FILE: design/edf_ifs.sv
// Valid/ready channel interfaces for scheduler ticks and tick results.
`timescale 1ns / 1ps
interface edf_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface edf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] tick_time;
  logic        busy_res;
  logic [1:0]  running_task;
  logic        job_finished;
  logic        job_dropped;

  modport source (output valid, output tick_time, output busy_res, output running_task,
                  output job_finished, output job_dropped, input ready);
  modport sink   (input valid, input tick_time, input busy_res, input running_task,
                  input job_finished, input job_dropped, output ready);
endinterface

FILE: design/edf_cell.sv
// One job slot: takes a pending release as the wave passes and forwards the best job so far.
`timescale 1ns / 1ps
module edf_cell #(
  parameter int unsigned TASKS     = 4,
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned IDX       = 0,
  localparam int unsigned TB = (TASKS > 1) ? $clog2(TASKS) : 1,
  localparam int unsigned SB = $clog2(SLOTS),
  localparam int unsigned FB = edf_pkg::FIELD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  edf_pkg::cell_cmd_t   cmd,
  input  logic [SB-1:0]        run_slot,
  input  logic [TIME_BITS-1:0] now,
  input  logic [TIME_BITS-1:0] task_dl [TASKS],
  input  logic [FB-1:0]        task_wcet [TASKS],
  // wave in
  input  logic                 in_active,
  input  logic [TASKS-1:0]     in_mask,
  input  logic                 in_bvalid,
  input  logic [SB-1:0]        in_bslot,
  input  logic [TIME_BITS-1:0] in_bdl,
  input  logic [TIME_BITS-1:0] in_brel,
  input  logic [TB-1:0]        in_btask,
  input  logic                 in_blast,
  // wave out
  output logic                 out_active,
  output logic [TASKS-1:0]     out_mask,
  output logic                 out_bvalid,
  output logic [SB-1:0]        out_bslot,
  output logic [TIME_BITS-1:0] out_bdl,
  output logic [TIME_BITS-1:0] out_brel,
  output logic [TB-1:0]        out_btask,
  output logic                 out_blast,
  output logic                 slot_valid
);

  logic [TB-1:0]        job_task;
  logic [TIME_BITS-1:0] deadline;
  logic [TIME_BITS-1:0] rel_time;
  logic [FB-1:0]        remaining;

  logic [TASKS-1:0]     pick;
  logic [TB-1:0]        pick_idx;
  logic                 take;
  logic                 sel;
  logic                 e_valid;
  logic [TB-1:0]        e_task;
  logic [TIME_BITS-1:0] e_dl;
  logic [TIME_BITS-1:0] e_rel;
  logic [FB-1:0]        e_rem;
  logic                 win;

  always_comb begin
    pick     = in_mask & (~in_mask + TASKS'(1));
    pick_idx = '0;
    for (int i = 0; i < TASKS; i++) begin
      if (pick[i]) pick_idx = TB'(i);
    end
    take    = in_active && !slot_valid && (in_mask != '0);
    e_valid = slot_valid || take;
    e_task  = take ? pick_idx : job_task;
    e_dl    = take ? task_dl[pick_idx] : deadline;
    e_rel   = take ? now : rel_time;
    e_rem   = take ? task_wcet[pick_idx] : remaining;
    // deadline ties go to the earlier release, then lower task; full ties to the lower slot
    win = e_valid && (!in_bvalid || (e_dl < in_bdl) ||
                      ((e_dl == in_bdl) && (e_rel < in_brel)) ||
                      ((e_dl == in_bdl) && (e_rel == in_brel) && (e_task < in_btask)));
  end

  assign sel = cmd.run && (run_slot == SB'(IDX));

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      out_active <= 1'b0;
    end else begin
      out_active <= in_active;
      if (cmd.clear) begin
        slot_valid <= 1'b0;
      end else if (take) begin
        slot_valid <= 1'b1;
      end else if (sel && remaining <= FB'(1)) begin
        slot_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_task  <= pick_idx;
      deadline  <= task_dl[pick_idx];
      rel_time  <= now;
      remaining <= task_wcet[pick_idx];
    end else if (sel && remaining != '0) begin
      remaining <= remaining - FB'(1);
    end
    out_mask <= take ? (in_mask & ~pick) : in_mask;
    if (win) begin
      out_bvalid <= 1'b1;
      out_bslot  <= SB'(IDX);
      out_bdl    <= e_dl;
      out_brel   <= e_rel;
      out_btask  <= e_task;
      out_blast  <= (e_rem <= FB'(1));
    end else begin
      out_bvalid <= in_bvalid;
      out_bslot  <= in_bslot;
      out_bdl    <= in_bdl;
      out_brel   <= in_brel;
      out_btask  <= in_btask;
      out_blast  <= in_blast;
    end
  end

endmodule

FILE: design/edf_tick_scheduler.sv
// Earliest-deadline-first tick scheduler: task release logic and a chain of job slot cells.
//
//   channel | dir | handshake           | payload
//   in_ch   | in  | valid/ready         | restart
//   out_ch  | out | valid/ready         | tick_time, busy_res, running_task,
//           |     |                     | job_finished, job_dropped
//   cfg     | in  | cfg_wr_en, no wait  | cfg_index, cfg_data
//
// A tick runs from accept through the setup states PREP and REL, a release and selection
// wave that moves one slot cell per cycle and is collected in WAVE, and RUN, which charges
// the winner and loads the output register. A new tick is accepted only back in IDLE, so
// the scheduler does not take a tick before the result of the last one is loaded.
// A result waiting on out_ch holds the scheduler in its final cycle and stalls the input.
// Reset (rst, synchronous) frees all slots, zeroes time, enables and task words.
`timescale 1ns / 1ps
module edf_tick_scheduler #(
  parameter int unsigned TASKS     = 4,
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TIME_BITS = 32,
  localparam int unsigned TB  = (TASKS > 1) ? $clog2(TASKS) : 1,
  localparam int unsigned SB  = $clog2(SLOTS),
  localparam int unsigned CIB = $clog2(TASKS + 2),
  localparam int unsigned FB  = edf_pkg::FIELD_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  edf_in_if.sink                             in_ch,
  edf_out_if.source                          out_ch,
  input  logic                               cfg_wr_en,
  input  logic [CIB-1:0]                     cfg_index,
  input  logic [edf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  typedef enum logic [2:0] {IDLE, PREP, REL, WAVE, RUN} state_t;

  state_t               state;
  logic [TASKS-1:0]     enable;
  logic [FB-1:0]        phase     [TASKS];
  logic [FB-1:0]        period    [TASKS];
  logic [FB-1:0]        wcet      [TASKS];
  logic [FB-1:0]        rdl       [TASKS];
  logic [FB-1:0]        countdown [TASKS];
  logic [TIME_BITS-1:0] task_dl   [TASKS];
  logic [TIME_BITS-1:0] cur_time;
  logic                 restart_q;
  logic                 l_active;
  logic [TASKS-1:0]     l_mask;
  logic                 bvalid;
  logic [SB-1:0]        bslot;
  logic [TB-1:0]        btask;
  logic                 blast;
  logic                 dropped_q;
  logic                 out_valid;

  logic [TASKS-1:0]     act;
  logic [TASKS-1:0]     rel;
  logic                 out_free;
  edf_pkg::cell_cmd_t   cmd;
  logic [SLOTS-1:0]     slot_vld;

  logic                 tk_active [SLOTS+1];
  logic [TASKS-1:0]     tk_mask   [SLOTS+1];
  logic                 tk_bvalid [SLOTS+1];
  logic [SB-1:0]        tk_bslot  [SLOTS+1];
  logic [TIME_BITS-1:0] tk_bdl    [SLOTS+1];
  logic [TIME_BITS-1:0] tk_brel   [SLOTS+1];
  logic [TB-1:0]        tk_btask  [SLOTS+1];
  logic                 tk_blast  [SLOTS+1];

  always_comb begin
    for (int t = 0; t < TASKS; t++) begin
      act[t] = enable[t] && (period[t] != '0) && (wcet[t] != '0);
      rel[t] = act[t] && (countdown[t] == '0);
    end
  end

  assign out_free    = !out_valid || out_ch.ready;
  assign cmd.clear   = (state == PREP) && restart_q;
  assign cmd.run     = (state == RUN) && out_free && bvalid;
  assign in_ch.ready = (state == IDLE);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= '0;
      for (int t = 0; t < TASKS; t++) begin
        phase[t]  <= '0;
        period[t] <= '0;
        wcet[t]   <= '0;
        rdl[t]    <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == CIB'(edf_pkg::CFG_ENABLE)) begin
        enable <= cfg_data[TASKS-1:0];
      end
      for (int t = 0; t < TASKS; t++) begin
        if (cfg_index == CIB'(edf_pkg::CFG_TASK_BASE + t)) begin
          phase[t]  <= cfg_data[edf_pkg::PHASE_LSB  +: FB];
          period[t] <= cfg_data[edf_pkg::PERIOD_LSB +: FB];
          wcet[t]   <= cfg_data[edf_pkg::WCET_LSB   +: FB];
          rdl[t]    <= cfg_data[edf_pkg::DLINE_LSB  +: FB];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cur_time  <= '0;
      restart_q <= 1'b0;
      l_active  <= 1'b0;
      out_valid <= 1'b0;
      for (int t = 0; t < TASKS; t++) countdown[t] <= '0;
    end else begin
      l_active <= 1'b0;
      if (out_ch.ready) out_valid <= 1'b0;
      if (cfg_wr_en) begin
        for (int t = 0; t < TASKS; t++) begin
          if (cfg_index == CIB'(edf_pkg::CFG_TASK_BASE + t)) begin
            countdown[t] <= cfg_data[edf_pkg::PHASE_LSB +: FB];
          end
        end
      end
      unique case (state)
        IDLE: begin
          if (in_ch.valid) begin
            restart_q <= in_ch.restart;
            state     <= PREP;
          end
        end
        PREP: begin
          if (restart_q) begin
            cur_time <= '0;
            for (int t = 0; t < TASKS; t++) countdown[t] <= phase[t];
          end
          state <= REL;
        end
        REL: begin
          for (int t = 0; t < TASKS; t++) begin
            if (act[t]) countdown[t] <= rel[t] ? period[t] - FB'(1) : countdown[t] - FB'(1);
            task_dl[t] <= cur_time + TIME_BITS'(rdl[t]);
          end
          l_mask   <= rel;
          l_active <= 1'b1;
          state    <= WAVE;
        end
        WAVE: begin
          if (tk_active[SLOTS]) begin
            bvalid    <= tk_bvalid[SLOTS];
            bslot     <= tk_bslot[SLOTS];
            btask     <= tk_btask[SLOTS];
            blast     <= tk_blast[SLOTS];
            dropped_q <= (tk_mask[SLOTS] != '0);
            state     <= RUN;
          end
        end
        RUN: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            out_ch.tick_time    <= 32'(cur_time);
            out_ch.busy_res     <= bvalid;
            out_ch.running_task <= bvalid ? 2'(btask) : 2'd0;
            out_ch.job_finished <= bvalid && blast;
            out_ch.job_dropped  <= dropped_q;
            cur_time            <= cur_time + TIME_BITS'(1);
            state               <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid;

  // wave entry
  assign tk_active[0] = l_active;
  assign tk_mask[0]   = l_mask;
  assign tk_bvalid[0] = 1'b0;
  assign tk_bslot[0]  = '0;
  assign tk_bdl[0]    = '0;
  assign tk_brel[0]   = '0;
  assign tk_btask[0]  = '0;
  assign tk_blast[0]  = 1'b0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    edf_cell #(
      .TASKS     (TASKS),
      .SLOTS     (SLOTS),
      .TIME_BITS (TIME_BITS),
      .IDX       (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .run_slot   (bslot),
      .now        (cur_time),
      .task_dl    (task_dl),
      .task_wcet  (wcet),
      .in_active  (tk_active[k]),
      .in_mask    (tk_mask[k]),
      .in_bvalid  (tk_bvalid[k]),
      .in_bslot   (tk_bslot[k]),
      .in_bdl     (tk_bdl[k]),
      .in_brel    (tk_brel[k]),
      .in_btask   (tk_btask[k]),
      .in_blast   (tk_blast[k]),
      .out_active (tk_active[k+1]),
      .out_mask   (tk_mask[k+1]),
      .out_bvalid (tk_bvalid[k+1]),
      .out_bslot  (tk_bslot[k+1]),
      .out_bdl    (tk_bdl[k+1]),
      .out_brel   (tk_brel[k+1]),
      .out_btask  (tk_btask[k+1]),
      .out_blast  (tk_blast[k+1]),
      .slot_valid (slot_vld[k])
    );
  end

  a_run_slot_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.run |-> slot_vld[bslot])
    else $error("selected slot is not holding a job");

  a_wave_in_wave: assert property (@(posedge clk) disable iff (rst)
    tk_active[SLOTS] |-> state == WAVE)
    else $error("wave left the chain outside the wave phase");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> slot_vld == '0)
    else $error("restart left a slot occupied");

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.busy_res) |-> (out_ch.running_task == 2'd0 && !out_ch.job_finished))
    else $error("idle tick reports a running job");

endmodule
